// ----- rtl/abad_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abad_pkg
// Shared constants and types of the adaptive binary arithmetic decoder.
// ----------------------------------------------------------------------------
package abad_pkg;

    localparam int CTX_BITS   = 8;
    localparam int COUNT_BITS = 28;
    localparam int CTX_DEPTH  = 1 << CTX_BITS;
    localparam int RANGE_BITS = 64;
    localparam int PROB_BITS  = 32;
    localparam int DEN_BITS   = COUNT_BITS + 2;
    localparam int CNT_W      = $clog2(PROB_BITS + 1);
    localparam int PEND_BITS  = 4;
    localparam int NORM_MAX   = 8;

    localparam logic FUNC_FEED   = 1'b0;
    localparam logic FUNC_DECODE = 1'b1;

    typedef logic [COUNT_BITS-1:0] t_count;
    typedef logic [DEN_BITS-1:0]   t_den;
    typedef logic [PROB_BITS-1:0]  t_prob;
    typedef logic [CTX_BITS-1:0]   t_ctx;
    typedef logic [PEND_BITS-1:0]  t_pend;

endpackage

// ----- rtl/abad_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abad_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module abad_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/abad_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abad_div
// Restoring serial divider that yields one quotient bit per cycle.
// ----------------------------------------------------------------------------
module abad_div
    import abad_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_den  i_num,
    input  t_den  i_den,
    output t_prob o_quot,
    output logic  o_done
);

    t_den             r_rem;
    t_den             r_den;
    t_prob            r_quot;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DEN_BITS:0] w_trial;
    logic              w_ge;
    logic [DEN_BITS:0] w_diff;

    assign w_trial = {r_rem, 1'b0};
    assign w_ge    = w_trial >= {1'b0, r_den};
    assign w_diff  = w_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem  <= i_num;
                r_den  <= i_den;
                r_quot <= '0;
                r_cnt  <= CNT_W'(PROB_BITS);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem  <= w_ge ? w_diff[DEN_BITS-1:0] : w_trial[DEN_BITS-1:0];
                r_quot <= {r_quot[PROB_BITS-2:0], w_ge};
                r_cnt  <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_quot = r_quot;
    assign o_done = r_done;

endmodule

// ----- rtl/adaptive_binary_arith_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adaptive_binary_arith_decoder
// Each request on the slave side is either a feed of one compressed byte
// (tuser 0) or a decode of one bit (tuser 1), and each gives one response.
// A feed goes through S_OUT to the response register, and a new request is
// accepted once S_IDLE is reached again. A decode goes through S_SPAN, S_MUL,
// S_ADD, S_CMP, S_UPD, S_RD2, S_DIVGO and S_DIV, where the 32-step serial
// divider forms the next probability, then S_OUT; the byte renormalization
// runs alongside the divider. Either request waits in S_OUT while a previous
// response is still held because m_axis_tready is low. The input is not ready
// while a request is in work. The response reports how many code bytes must be
// fed before the next decode; requests out of order flag an error and change
// nothing. The count store is cleared at reset through per-context valid
// flags, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module adaptive_binary_arith_decoder
    import abad_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,  // [7:0] code_byte
    input  logic       s_axis_tuser,  // [0] func
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata   // [0] bit_res, [4:1] bytes_wanted, [5] error
);

    typedef enum logic [3:0] {
        S_IDLE, S_SPAN, S_MUL, S_ADD, S_CMP, S_UPD, S_RD2, S_DIVGO, S_DIV, S_OUT
    } t_state;

    t_state                r_state;
    logic [RANGE_BITS-1:0] r_low;
    logic [RANGE_BITS-1:0] r_high;
    logic [RANGE_BITS-1:0] r_code;
    logic [RANGE_BITS-1:0] r_tmp;
    t_prob                 r_prob;
    t_ctx                  r_ctx;
    t_pend                 r_pending;
    t_pend                 r_n;
    logic                  r_bit;
    logic [CTX_DEPTH-1:0]  r_valid;
    logic                  r_rd_valid;
    logic                  r_res_bit;
    t_pend                 r_res_bytes;
    logic                  r_res_err;
    logic                  r_o_valid;
    logic                  r_o_bit;
    t_pend                 r_o_bytes;
    logic                  r_o_err;

    logic [RANGE_BITS-1:0]   w_prod;
    logic                    w_ram_we;
    logic                    w_ram_re;
    logic [2*COUNT_BITS-1:0] w_wdata;
    logic [2*COUNT_BITS-1:0] w_rdata;
    t_count                  w_z;
    t_count                  w_o;
    logic [COUNT_BITS:0]     w_inc;
    logic                    w_ovf;
    t_count                  w_z_new;
    t_count                  w_o_new;
    t_den                    w_num;
    t_den                    w_den;
    t_prob                   w_quot;
    logic                    w_div_done;
    logic                    w_norm;
    logic                    w_in_acc;

    assign w_prod   = r_tmp[RANGE_BITS-1:PROB_BITS] * r_prob;
    assign w_in_acc = s_axis_tvalid && s_axis_tready;

    assign w_z   = r_rd_valid ? w_rdata[COUNT_BITS-1:0] : '0;
    assign w_o   = r_rd_valid ? w_rdata[2*COUNT_BITS-1:COUNT_BITS] : '0;
    assign w_inc = r_bit ? ({1'b0, w_o} + (COUNT_BITS+1)'(1))
                         : ({1'b0, w_z} + (COUNT_BITS+1)'(1));
    assign w_ovf = w_inc[COUNT_BITS];

    always_comb begin
        if (r_bit) begin
            w_o_new = w_ovf ? w_inc[COUNT_BITS:1] : w_inc[COUNT_BITS-1:0];
            w_z_new = w_ovf ? (w_z >> 1) : w_z;
        end else begin
            w_z_new = w_ovf ? w_inc[COUNT_BITS:1] : w_inc[COUNT_BITS-1:0];
            w_o_new = w_ovf ? (w_o >> 1) : w_o;
        end
    end

    assign w_wdata  = {w_o_new, w_z_new};
    assign w_ram_we = r_state == S_UPD;
    assign w_ram_re = (r_state == S_ADD) || (r_state == S_RD2);

    assign w_num = DEN_BITS'(w_o) + DEN_BITS'(1);
    assign w_den = DEN_BITS'(w_z) + DEN_BITS'(w_o) + DEN_BITS'(2);

    assign w_norm = (r_n < PEND_BITS'(NORM_MAX)) &&
                    (r_low[RANGE_BITS-1:RANGE_BITS-8] == r_high[RANGE_BITS-1:RANGE_BITS-8]);

    abad_ram #(
        .WIDTH (2 * COUNT_BITS),
        .DEPTH (CTX_DEPTH)
    ) u_counts (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_ctx),
        .i_wdata (w_wdata),
        .i_re    (w_ram_re),
        .i_raddr (r_ctx),
        .o_rdata (w_rdata)
    );

    abad_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_DIVGO),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_quot  (w_quot),
        .o_done  (w_div_done)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_low     <= '0;
            r_high    <= '1;
            r_code    <= '0;
            r_prob    <= '1;
            r_ctx     <= '0;
            r_pending <= PEND_BITS'(NORM_MAX);
            r_n       <= '0;
            r_valid   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready && (r_state != S_OUT)) begin
                r_o_valid <= 1'b0;
            end
            if (w_ram_re) begin
                r_rd_valid <= r_valid[r_ctx];
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_res_bit <= 1'b0;
                        if (s_axis_tuser == FUNC_FEED) begin
                            r_state <= S_OUT;
                            if (r_pending == '0) begin
                                r_res_err   <= 1'b1;
                                r_res_bytes <= '0;
                            end else begin
                                r_code      <= {r_code[RANGE_BITS-9:0], s_axis_tdata};
                                r_pending   <= r_pending - PEND_BITS'(1);
                                r_res_err   <= 1'b0;
                                r_res_bytes <= r_pending - PEND_BITS'(1);
                            end
                        end else if (r_pending != '0) begin
                            r_state     <= S_OUT;
                            r_res_err   <= 1'b1;
                            r_res_bytes <= r_pending;
                        end else begin
                            r_state <= S_SPAN;
                        end
                    end
                end
                S_SPAN: begin
                    r_tmp   <= r_high - r_low;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_tmp   <= w_prod;
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    r_tmp   <= r_low + r_tmp;
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    r_n <= '0;
                    if (r_code <= r_tmp) begin
                        r_bit  <= 1'b1;
                        r_high <= r_tmp;
                    end else begin
                        r_bit  <= 1'b0;
                        r_low  <= r_tmp + RANGE_BITS'(1);
                    end
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    r_valid[r_ctx] <= 1'b1;
                    r_ctx          <= CTX_BITS'({r_ctx, r_bit});
                    r_state        <= S_RD2;
                end
                S_RD2: begin
                    r_state <= S_DIVGO;
                end
                S_DIVGO: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_norm) begin
                        r_low  <= {r_low[RANGE_BITS-9:0], 8'h00};
                        r_high <= {r_high[RANGE_BITS-9:0], 8'hFF};
                        r_n    <= r_n + PEND_BITS'(1);
                    end
                    if (w_div_done) begin
                        r_prob      <= w_quot;
                        r_pending   <= r_n;
                        r_res_bit   <= r_bit;
                        r_res_bytes <= r_n;
                        r_res_err   <= 1'b0;
                        r_state     <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_o_valid || m_axis_tready) begin
                        r_o_valid <= 1'b1;
                        r_o_bit   <= r_res_bit;
                        r_o_bytes <= r_res_bytes;
                        r_o_err   <= r_res_err;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = r_state == S_IDLE;
    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = {2'b00, r_o_err, r_o_bytes, r_o_bit};

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> !s_axis_tready)
        else $error("input accepted while a request is in work");

    a_pending_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pending <= PEND_BITS'(NORM_MAX)) && (r_n <= PEND_BITS'(NORM_MAX)))
        else $error("pending byte count out of range");

    a_err_no_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && r_o_err |-> !r_o_bit)
        else $error("error response carries a decoded bit");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> r_state == S_DIV)
        else $error("divider finished outside the divide state");

    a_norm_before_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> !w_norm)
        else $error("renormalization still running when the divider finished");
`endif

endmodule
